@@ hw/rtl/fld_pkg.sv @@
// shared types and codes for the framebuffer line draw block
`default_nettype none
package fld_pkg;

    localparam logic [1:0] ACT_SET   = 2'd0;
    localparam logic [1:0] ACT_GET   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_LINE  = 2'd3;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        SEL_N,
        SEL_X,
        SEL_Y
    } t_sel;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SET,
        ST_GET,
        ST_CLEAR,
        ST_SETUP,
        ST_SQN_GO,
        ST_SQN_WAIT,
        ST_DIVX_GO,
        ST_DIVX_WAIT,
        ST_SQX_GO,
        ST_SQX_WAIT,
        ST_DIVY_GO,
        ST_DIVY_WAIT,
        ST_SQY_GO,
        ST_SQY_WAIT,
        ST_DRAW,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic setup;
        logic sq_go;
        logic sq_cap;
        logic div_go;
        t_sel sel;
        logic line_step;
        logic clr_step;
        logic set_wr;
        logic get_rd;
    } t_cmd;

    typedef struct packed {
        logic       sq_busy;
        logic       div_busy;
        logic       s_zero;
        logic       line_last;
        logic       clr_last;
    } t_stat;

endpackage
`default_nettype wire

@@ hw/rtl/fld_ctrl.sv @@
// command sequencer for the framebuffer line draw block
`default_nettype none
module fld_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic [1:0]    i_action,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire fld_pkg::t_stat i_stat,
    output fld_pkg::t_cmd      o_cmd
);
    import fld_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_action)
                        ACT_SET:   n_state = ST_SET;
                        ACT_GET:   n_state = ST_GET;
                        ACT_CLEAR: n_state = ST_CLEAR;
                        default:   n_state = ST_SETUP;
                    endcase
                end
            end
            ST_SET:      n_state = ST_RESP;
            ST_GET:      n_state = ST_RESP;
            ST_CLEAR:    if (i_stat.clr_last) n_state = ST_RESP;
            ST_SETUP:    n_state = ST_SQN_GO;
            ST_SQN_GO:   n_state = ST_SQN_WAIT;
            ST_SQN_WAIT: begin
                if (!i_stat.sq_busy) begin
                    n_state = i_stat.s_zero ? ST_RESP : ST_DIVX_GO;
                end
            end
            ST_DIVX_GO:   n_state = ST_DIVX_WAIT;
            ST_DIVX_WAIT: if (!i_stat.div_busy) n_state = ST_SQX_GO;
            ST_SQX_GO:    n_state = ST_SQX_WAIT;
            ST_SQX_WAIT:  if (!i_stat.sq_busy) n_state = ST_DIVY_GO;
            ST_DIVY_GO:   n_state = ST_DIVY_WAIT;
            ST_DIVY_WAIT: if (!i_stat.div_busy) n_state = ST_SQY_GO;
            ST_SQY_GO:    n_state = ST_SQY_WAIT;
            ST_SQY_WAIT:  if (!i_stat.sq_busy) n_state = ST_DRAW;
            ST_DRAW:      if (i_stat.line_last) n_state = ST_RESP;
            ST_RESP:      if (i_out_ready) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.sel   = SEL_N;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_SET:   o_cmd.set_wr = 1'b1;
            ST_GET:   o_cmd.get_rd = 1'b1;
            ST_CLEAR: o_cmd.clr_step = 1'b1;
            ST_SETUP: o_cmd.setup = 1'b1;
            ST_SQN_GO: begin
                o_cmd.sq_go = 1'b1;
                o_cmd.sel   = SEL_N;
            end
            ST_SQN_WAIT: begin
                o_cmd.sq_cap = !i_stat.sq_busy;
                o_cmd.sel    = SEL_N;
            end
            ST_DIVX_GO: begin
                o_cmd.div_go = 1'b1;
                o_cmd.sel    = SEL_X;
            end
            ST_DIVX_WAIT: o_cmd.sel = SEL_X;
            ST_SQX_GO: begin
                o_cmd.sq_go = 1'b1;
                o_cmd.sel   = SEL_X;
            end
            ST_SQX_WAIT: begin
                o_cmd.sq_cap = !i_stat.sq_busy;
                o_cmd.sel    = SEL_X;
            end
            ST_DIVY_GO: begin
                o_cmd.div_go = 1'b1;
                o_cmd.sel    = SEL_Y;
            end
            ST_DIVY_WAIT: o_cmd.sel = SEL_Y;
            ST_SQY_GO: begin
                o_cmd.sq_go = 1'b1;
                o_cmd.sel   = SEL_Y;
            end
            ST_SQY_WAIT: begin
                o_cmd.sq_cap = !i_stat.sq_busy;
                o_cmd.sel    = SEL_Y;
            end
            ST_DRAW: o_cmd.line_step = 1'b1;
            ST_RESP: o_out_valid = 1'b1;
            default: o_cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

@@ hw/rtl/fld_dp.sv @@
// datapath: pixel store, shared sqrt and divide units, line and clear walkers
`default_nettype none
module fld_dp #(
    parameter int MAX_WIDTH      = 64,
    parameter int MAX_HEIGHT     = 64,
    parameter int STEP_FRAC_BITS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire fld_pkg::t_cmd i_cmd,
    output fld_pkg::t_stat     o_stat,
    input  wire logic [6:0]    i_width,
    input  wire logic [6:0]    i_height,
    input  wire logic [1:0]    i_action,
    input  wire logic [63:0]   i_data,
    output logic               o_read_valid,
    output logic [31:0]        o_data
);
    import fld_pkg::*;

    localparam int F     = STEP_FRAC_BITS;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = (AW > 9) ? AW : 9;
    localparam int NW    = 16 + 2 * F;
    localparam int QW    = 2 * F + 1;
    localparam int SQW   = 2 * F + 2;
    localparam int RW    = F + 1;
    localparam int IW    = 11;
    localparam int PW    = F + IW;
    localparam int SCW   = $clog2(RW + 1);
    localparam int DCW   = $clog2(NW + 1);

    logic [31:0] mem [DEPTH];

    logic signed [7:0] r_x0, r_y0, r_x1, r_y1;
    logic [31:0]       r_color;
    logic              r_is_get;
    logic [15:0]       r_dx2, r_dy2;
    logic              r_dxneg, r_dyneg;
    logic [16:0]       r_s;
    logic [8:0]        r_n;
    logic [F:0]        r_sx, r_sy;
    logic [PW-1:0]     r_px, r_py;
    logic [CW-1:0]     r_cnt;
    logic [31:0]       r_rd;

    logic [SQW-1:0]    r_sq_op;
    logic [RW+1:0]     r_sq_rem;
    logic [RW-1:0]     r_sq_root;
    logic [SCW-1:0]    r_sq_cnt;
    logic              r_sq_busy;
    t_sel              r_sq_sel;

    logic [NW-1:0]     r_dv_num;
    logic [16:0]       r_dv_rem;
    logic [QW-1:0]     r_q;
    logic [DCW-1:0]    r_dv_cnt;
    logic              r_dv_busy;

    function automatic logic [13:0] pix_addr(input logic [6:0] x, input logic [6:0] y,
                                             input logic [6:0] w);
        pix_addr = {7'd0, x} + 14'(w * y);
    endfunction

    // setup arithmetic
    logic signed [8:0] dx, dy;
    logic [7:0]        adx, ady;
    always_comb begin
        dx  = 9'(r_x1) - 9'(r_x0);
        dy  = 9'(r_y1) - 9'(r_y0);
        adx = dx[8] ? 8'(-dx) : 8'(dx);
        ady = dy[8] ? 8'(-dy) : 8'(dy);
    end

    // sqrt recurrence, two operand bits a step
    logic [RW+3:0] sq_sh, sq_trial;
    logic          sq_ge;
    always_comb begin
        sq_sh    = {r_sq_rem, r_sq_op[SQW-1 -: 2]};
        sq_trial = {2'b00, r_sq_root, 2'b01};
        sq_ge    = sq_sh >= sq_trial;
    end

    // restoring divide, one quotient bit a step
    logic [17:0] dv_sh;
    logic        dv_ge;
    always_comb begin
        dv_sh = {r_dv_rem, r_dv_num[NW-1]};
        dv_ge = dv_sh >= {1'b0, r_s};
    end

    // line point: truncate toward zero
    logic [PW-1:0] apx, apy, sxe, sye;
    logic [IW-1:0] tx, ty;
    logic          line_in;
    always_comb begin
        apx = r_px[PW-1] ? -r_px : r_px;
        apy = r_py[PW-1] ? -r_py : r_py;
        tx  = r_px[PW-1] ? -apx[PW-1:F] : apx[PW-1:F];
        ty  = r_py[PW-1] ? -apy[PW-1:F] : apy[PW-1:F];
        line_in = !tx[IW-1] && !ty[IW-1]
               && (tx[IW-2:0] < {3'd0, i_width}) && (ty[IW-2:0] < {3'd0, i_height});
        sxe = {{(PW-F-1){1'b0}}, r_sx};
        sye = {{(PW-F-1){1'b0}}, r_sy};
    end

    // get_pixel clamp
    logic [6:0] cx, cy;
    always_comb begin
        if (r_x0[7])                   cx = 7'd0;
        else if (r_x0[6:0] >= i_width) cx = i_width - 7'd1;
        else                           cx = r_x0[6:0];
        if (r_y0[7])                    cy = 7'd0;
        else if (r_y0[6:0] >= i_height) cy = i_height - 7'd1;
        else                            cy = r_y0[6:0];
    end

    logic [13:0] wh;
    logic        set_in;
    always_comb begin
        wh     = 14'(i_width * i_height);
        set_in = !r_x0[7] && !r_y0[7] && (r_x0[6:0] < i_width) && (r_y0[6:0] < i_height);
    end

    logic          we;
    logic [AW-1:0] waddr;
    always_comb begin
        we    = 1'b0;
        waddr = r_cnt[AW-1:0];
        if (i_cmd.set_wr) begin
            we    = set_in;
            waddr = AW'(pix_addr(r_x0[6:0], r_y0[6:0], i_width));
        end else if (i_cmd.line_step) begin
            we    = line_in;
            waddr = AW'(pix_addr(tx[6:0], ty[6:0], i_width));
        end else if (i_cmd.clr_step) begin
            we    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= r_color;
        end
        if (i_cmd.get_rd) begin
            r_rd <= mem[AW'(pix_addr(cx, cy, i_width))];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x0     <= i_data[7:0];
            r_y0     <= i_data[15:8];
            r_x1     <= i_data[23:16];
            r_y1     <= i_data[31:24];
            r_color  <= i_data[63:32];
            r_is_get <= (i_action == ACT_GET);
            r_px     <= {{(IW-8){i_data[7]}}, i_data[7:0], F'(0)};
            r_py     <= {{(IW-8){i_data[15]}}, i_data[15:8], F'(0)};
        end else if (i_cmd.line_step) begin
            r_px <= r_px + (r_dxneg ? -sxe : sxe);
            r_py <= r_py + (r_dyneg ? -sye : sye);
        end
        if (i_cmd.setup) begin
            r_dx2   <= adx * adx;
            r_dy2   <= ady * ady;
            r_dxneg <= dx[8];
            r_dyneg <= dy[8];
            r_s     <= 17'(adx * adx) + 17'(ady * ady);
        end
        if (i_cmd.sq_cap) begin
            unique case (i_cmd.sel)
                SEL_N:   r_n  <= 9'(r_sq_root) + {8'd0, (r_sq_rem != '0)};
                SEL_X:   r_sx <= r_sq_root[F:0];
                SEL_Y:   r_sy <= r_sq_root[F:0];
                default: r_n  <= r_n;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.line_step || i_cmd.clr_step) begin
            r_cnt <= r_cnt + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_busy <= 1'b0;
            r_sq_cnt  <= '0;
        end else if (i_cmd.sq_go) begin
            r_sq_busy <= 1'b1;
            r_sq_cnt  <= SCW'(RW);
        end else if (r_sq_busy) begin
            r_sq_cnt <= r_sq_cnt - SCW'(1);
            if (r_sq_cnt == SCW'(1)) begin
                r_sq_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_go) begin
            r_sq_sel  <= i_cmd.sel;
            r_sq_op   <= (i_cmd.sel == SEL_N) ? SQW'(r_s) : SQW'(r_q);
            r_sq_rem  <= '0;
            r_sq_root <= '0;
        end else if (r_sq_busy) begin
            r_sq_op   <= {r_sq_op[SQW-3:0], 2'b00};
            r_sq_rem  <= sq_ge ? (RW+2)'(sq_sh - sq_trial) : (RW+2)'(sq_sh);
            r_sq_root <= {r_sq_root[RW-2:0], sq_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_busy <= 1'b0;
            r_dv_cnt  <= '0;
        end else if (i_cmd.div_go) begin
            r_dv_busy <= 1'b1;
            r_dv_cnt  <= DCW'(NW);
        end else if (r_dv_busy) begin
            r_dv_cnt <= r_dv_cnt - DCW'(1);
            if (r_dv_cnt == DCW'(1)) begin
                r_dv_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_go) begin
            r_dv_num <= {(i_cmd.sel == SEL_X) ? r_dx2 : r_dy2, (2*F)'(0)};
            r_dv_rem <= '0;
            r_q      <= '0;
        end else if (r_dv_busy) begin
            r_dv_num <= {r_dv_num[NW-2:0], 1'b0};
            r_dv_rem <= dv_ge ? 17'(dv_sh - {1'b0, r_s}) : 17'(dv_sh);
            r_q      <= {r_q[QW-2:0], dv_ge};
        end
    end

    always_comb begin
        o_stat.sq_busy   = r_sq_busy;
        o_stat.div_busy  = r_dv_busy;
        o_stat.s_zero    = (r_s == '0) || (r_sq_sel != SEL_N && 1'b0);
        o_stat.line_last = (r_cnt[8:0] == r_n - 9'd1);
        o_stat.clr_last  = (r_cnt[AW-1:0] == AW'(wh - 14'd1));
        o_read_valid     = r_is_get;
        o_data           = r_is_get ? r_rd : 32'd0;
    end
endmodule
`default_nettype wire

@@ hw/rtl/framebuffer_line_draw.sv @@
// top level: configuration registers, stream ports, sequencer and datapath
// Usage: commands enter on the s_axis channel, one word per command;
// s_axis_tuser carries the action, s_axis_tdata the coordinates and color.
// Every command returns exactly one word on m_axis; m_axis_tuser is set
// for get_pixel, whose channels come in m_axis_tdata (zero otherwise).
// One command is in flight at a time: s_axis_tready is high only when idle.
// set_pixel and get_pixel access the store and then return the result
// word; clear writes one pixel per cycle through the store's write
// port. draw_line first runs its setup (one sqrt for the point count,
// then per axis a bit-serial divide and sqrt) and then walks the line
// point by point; a zero-length line skips the walk. The result word
// holds on m_axis until m_axis_tready is seen. Reset returns to idle
// and sets width and height to 64 (or the maximum); pixels are
// undefined until written. Sizes are written over the APB port at
// addresses 0 and 4 while idle; 0 reads as 1, large values clip.
`default_nettype none
module framebuffer_line_draw #(
    parameter int MAX_WIDTH      = 64,
    parameter int MAX_HEIGHT     = 64,
    parameter int STEP_FRAC_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // x0, y0, x1, y1, red, green, blue, alpha
    input  wire logic [63:0] s_axis_tdata,
    // action
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [31:0]      m_axis_tdata,
    // read_valid
    output logic             m_axis_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import fld_pkg::*;

    localparam int W_RST = (MAX_WIDTH < 64) ? MAX_WIDTH : 64;
    localparam int H_RST = (MAX_HEIGHT < 64) ? MAX_HEIGHT : 64;

    logic [6:0] r_width, r_height;
    logic [6:0] wval;
    logic       wr;
    t_cmd       cmd;
    t_stat      stat;

    function automatic logic [6:0] clamp_size(input logic [6:0] v, input int lim);
        if (v == 7'd0)                clamp_size = 7'd1;
        else if (int'(v) > lim)       clamp_size = 7'(lim);
        else                          clamp_size = v;
    endfunction

    always_comb begin
        pready = 1'b1;
        wr     = psel && penable && pwrite;
        wval   = pwdata[6:0];
        prdata = {25'd0, (paddr[2] == REG_HEIGHT) ? r_height : r_width};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 7'(W_RST);
            r_height <= 7'(H_RST);
        end else if (wr) begin
            if (paddr[2] == REG_WIDTH) begin
                r_width <= clamp_size(wval, MAX_WIDTH);
            end else begin
                r_height <= clamp_size(wval, MAX_HEIGHT);
            end
        end
    end

    fld_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_action    (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    fld_dp #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_HEIGHT     (MAX_HEIGHT),
        .STEP_FRAC_BITS (STEP_FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_width      (r_width),
        .i_height     (r_height),
        .i_action     (s_axis_tuser),
        .i_data       (s_axis_tdata),
        .o_read_valid (m_axis_tuser),
        .o_data       (m_axis_tdata)
    );
endmodule
`default_nettype wire

@@ bench/framebuffer_line_draw_tb.sv @@
// self-checking bench for the framebuffer line draw block with a pixel-store predictor
module framebuffer_line_draw_tb;
    import fld_pkg::*;

    localparam int MAXW = 64;
    localparam int MAXH = 64;
    localparam int FRAC = 16;
    localparam int N_RAND = 730;

    typedef struct packed {
        logic        rd;
        logic [31:0] rgba;
    } t_pix_word;

    class fb_scoreboard;
        logic [31:0] pixels [MAXW*MAXH];
        bit          written [MAXW*MAXH];
        int          width = MAXW;
        int          height = MAXH;
        t_pix_word   pending [$];
        int          errors = 0;

        function int clip_size(int v);
            if (v == 0) return 1;
            if (v > MAXW) return MAXW;
            return v;
        endfunction

        function void set_size(logic idx, int v);
            if (idx == REG_WIDTH) width = clip_size(v & 'h7f);
            else height = clip_size(v & 'h7f);
        endfunction

        function void plot(int x, int y, logic [31:0] c);
            if (x < 0 || y < 0 || x >= width || y >= height) return;
            pixels[x + width*y] = c;
            written[x + width*y] = 1;
        endfunction

        function longint unsigned root(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function longint step_of(int d, longint unsigned s);
            longint unsigned m;
            if (d == 0 || s == 0) return 0;
            m = root((longint'(d*d) << (2*FRAC)) / s);
            return d < 0 ? -longint'(m) : longint'(m);
        endfunction

        function int to_pixel(longint v);
            if (v < 0) return -int'((-v) >>> FRAC);
            return int'(v >>> FRAC);
        endfunction

        function void walk_line(int xa, int ya, int xb, int yb, logic [31:0] c);
            longint unsigned s;
            longint unsigned r;
            longint unsigned n;
            longint sx;
            longint sy;
            longint px;
            longint py;
            s = (xb-xa)*(xb-xa) + (yb-ya)*(yb-ya);
            r = root(s);
            n = r + ((r*r < s) ? 1 : 0);
            sx = step_of(xb-xa, s);
            sy = step_of(yb-ya, s);
            px = longint'(xa) <<< FRAC;
            py = longint'(ya) <<< FRAC;
            for (longint unsigned i = 0; i < n; i++) begin
                plot(to_pixel(px), to_pixel(py), c);
                px += sx;
                py += sy;
            end
        endfunction

        function int clampc(int v, int lim);
            if (v < 0) return 0;
            if (v >= lim) return lim - 1;
            return v;
        endfunction

        // the get-pixel target after clamping; used to avoid unwritten reads
        function bit readable(int x, int y);
            return written[clampc(x, width) + width*clampc(y, height)];
        endfunction

        function void note_command(logic [1:0] act, logic [63:0] d);
            int xa, ya, xb, yb;
            logic [31:0] c;
            t_pix_word w;
            xa = $signed(d[7:0]);
            ya = $signed(d[15:8]);
            xb = $signed(d[23:16]);
            yb = $signed(d[31:24]);
            c = d[63:32];
            w = '0;
            case (act)
                ACT_SET: plot(xa, ya, c);
                ACT_GET: begin
                    w.rd = 1;
                    w.rgba = pixels[clampc(xa, width) + width*clampc(ya, height)];
                end
                ACT_CLEAR: begin
                    for (int i = 0; i < width*height; i++) begin
                        pixels[i] = c;
                        written[i] = 1;
                    end
                end
                default: walk_line(xa, ya, xb, yb, c);
            endcase
            pending.push_back(w);
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_result(logic rd, logic [31:0] data);
            t_pix_word w;
            if (pending.size() == 0) begin
                report("result word with nothing expected");
                return;
            end
            w = pending.pop_front();
            if (rd !== w.rd) report($sformatf("read flag %b, want %b", rd, w.rd));
            if (data[7:0] !== w.rgba[7:0])
                report($sformatf("red %h, want %h", data[7:0], w.rgba[7:0]));
            if (data[15:8] !== w.rgba[15:8])
                report($sformatf("green %h, want %h", data[15:8], w.rgba[15:8]));
            if (data[23:16] !== w.rgba[23:16])
                report($sformatf("blue %h, want %h", data[23:16], w.rgba[23:16]));
            if (data[31:24] !== w.rgba[31:24])
                report($sformatf("alpha %h, want %h", data[31:24], w.rgba[31:24]));
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    fb_scoreboard fb = new();
    bit           hold_long = 0;
    bit           rx_fast = 0;

    framebuffer_line_draw u_top (.*);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #400_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task apb_write(logic idx, int v);
        @(posedge i_clk);
        psel <= 1;
        paddr <= {idx, 2'b00};
        pwrite <= 1;
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        fb.set_size(idx, v);
    endtask

    // valid stays up after an accept until a gap or drain drops it
    task send_word(logic [1:0] act, logic [63:0] d, bit gaps);
        int n;
        n = gaps ? $urandom_range(0, 8) : 0;
        if (n > 0) begin
            s_axis_tvalid <= 0;
            repeat (n) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= act;
        s_axis_tdata <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        fb.note_command(act, d);
    endtask

    function logic [63:0] pack_cmd(int xa, int ya, int xb, int yb, logic [31:0] c);
        return {c, yb[7:0], xb[7:0], ya[7:0], xa[7:0]};
    endfunction

    function int coord(int lim);
        // mostly in or near the image, sometimes anywhere
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255) - 128;
        return $urandom_range(0, lim + 3) - 2;
    endfunction

    // one random command; a get is only issued where its pixel is known
    task random_command(bit gaps);
        int k, xa, ya, xb, yb, w, h;
        logic [1:0] act;
        w = fb.width;
        h = fb.height;
        k = $urandom_range(0, 99);
        xa = coord(w);
        ya = coord(h);
        if ($urandom_range(0, 3) == 0) begin
            xb = xa + $urandom_range(0, 6) - 3;
            yb = ya + $urandom_range(0, 6) - 3;
            if (xb > 127) xb = 127;
            if (yb > 127) yb = 127;
        end else begin
            xb = coord(w);
            yb = coord(h);
        end
        if (k < 30) act = ACT_SET;
        else if (k < 70) act = ACT_GET;
        else if (k < 72) act = ACT_CLEAR;
        else act = ACT_LINE;
        if (act == ACT_GET && !fb.readable(xa, ya)) act = ACT_SET;
        send_word(act, pack_cmd(xa, ya, xb, yb, $urandom), gaps);
    endtask

    task drain;
        s_axis_tvalid <= 0;
        while (fb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            if (hold_long) begin
                m_axis_tready <= 0;
                repeat (3000) @(posedge i_clk);
                hold_long = 0;
            end
            n = rx_fast ? 0 : $urandom_range(0, 8);
            if (n > 0) begin
                m_axis_tready <= 0;
                repeat (n) @(posedge i_clk);
            end
            m_axis_tready <= 1;
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                fb.check_result(m_axis_tuser, m_axis_tdata);
        end
    end

    initial begin
        logic [31:0] full;
        full = 32'hffff_ffff;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: small image, clear, corner writes and reads, then lines
        apb_write(REG_WIDTH, 0);
        apb_write(REG_HEIGHT, 200);
        apb_write(REG_WIDTH, 8);
        apb_write(REG_HEIGHT, 5);
        send_word(ACT_CLEAR, pack_cmd(0, 0, 0, 0, 32'h8040_2010), 0);
        send_word(ACT_GET, pack_cmd(-128, -128, 0, 0, 0), 0);
        send_word(ACT_SET, pack_cmd(7, 4, 0, 0, full), 0);
        send_word(ACT_GET, pack_cmd(127, 127, -1, -1, 0), 0);
        send_word(ACT_SET, pack_cmd(8, 0, 0, 0, 0), 0);
        send_word(ACT_SET, pack_cmd(-1, 2, 0, 0, 0), 0);
        send_word(ACT_GET, pack_cmd(7, 0, 0, 0, 0), 0);
        send_word(ACT_LINE, pack_cmd(3, 3, 3, 3, 32'h1234_5678), 0);
        send_word(ACT_LINE, pack_cmd(-128, -128, 127, 127, 32'h5555_aaaa), 0);
        send_word(ACT_LINE, pack_cmd(127, -128, -128, 127, 32'haaaa_5555), 0);
        send_word(ACT_LINE, pack_cmd(0, 0, 7, 4, 32'h0f0f_f0f0), 0);
        send_word(ACT_LINE, pack_cmd(7, 4, 0, 0, 32'hf0f0_0f0f), 0);
        for (int x = 0; x < 8; x++) send_word(ACT_GET, pack_cmd(x, x / 2, 0, 0, 0), 0);
        drain();

        // random phases across image sizes, including the extremes
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin apb_write(REG_WIDTH, 1); apb_write(REG_HEIGHT, 1); end
                1: begin apb_write(REG_WIDTH, 64); apb_write(REG_HEIGHT, 1); end
                2: begin apb_write(REG_WIDTH, 127); apb_write(REG_HEIGHT, 64); end
                default: begin
                    apb_write(REG_WIDTH, $urandom_range(1, 20));
                    apb_write(REG_HEIGHT, $urandom_range(1, 20));
                end
            endcase
            // a store reshape invalidates what was known to be written
            for (int i = 0; i < MAXW*MAXH; i++) fb.written[i] = 0;
            if ($urandom_range(0, 1))
                send_word(ACT_CLEAR, pack_cmd(0, 0, 0, 0, $urandom), 1);
            if (ph == 3) begin
                hold_long = 1;
                for (int i = 0; i < 20; i++) random_command(0);
            end
            rx_fast = (ph == 4);
            for (int i = 0; i < N_RAND / 6; i++) random_command(ph != 4);
            drain();
        end

        if (fb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
